[rtl/hsl2rgb_pkg.sv]
// Shared types, constants and helper functions for the HSL to RGB converter.
`default_nettype none

package hsl2rgb_pkg;

  // Field widths
  localparam int HUE_W  = 9;
  localparam int PCT_W  = 7;
  localparam int BYTE_W = 8;
  localparam int NUM_W  = 15;  // numerators over 10000, up to 20000
  localparam int RAMP_W = 6;   // ramp position 0..60

  // Percent limits
  localparam logic [PCT_W-1:0] PCT_MAX  = 7'd100;
  localparam logic [PCT_W-1:0] PCT_HALF = 7'd50;

  // Degree breakpoints
  localparam logic [HUE_W:0]   DEG_FULL   = 10'd360;
  localparam logic [HUE_W:0]   DEG_RED    = 10'd120;
  localparam logic [HUE_W:0]   DEG_BLUE   = 10'd240;
  localparam logic [HUE_W-1:0] DEG_SIXTH  = 9'd60;
  localparam logic [HUE_W-1:0] DEG_HALF   = 9'd180;
  localparam logic [HUE_W-1:0] DEG_TWO3   = 9'd240;

  // Ramp positions of the three channels
  typedef struct packed {
    logic [RAMP_W-1:0] r;
    logic [RAMP_W-1:0] g;
    logic [RAMP_W-1:0] b;
  } ramp_t;

  // Grey bypass: flag and truncated level
  typedef struct packed {
    logic              grey;
    logic [BYTE_W-1:0] level;
  } grey_t;

  // Map a phase in degrees to its ramp position k (0..60)
  function automatic logic [RAMP_W-1:0] ramp_of(input logic [HUE_W-1:0] d);
    logic [HUE_W-1:0] down;
    logic [RAMP_W-1:0] k;
    down = DEG_TWO3 - d;
    if (d < DEG_SIXTH) begin
      k = d[RAMP_W-1:0];
    end else if (d < DEG_HALF) begin
      k = DEG_SIXTH[RAMP_W-1:0];
    end else if (d < DEG_TWO3) begin
      k = down[RAMP_W-1:0];
    end else begin
      k = '0;
    end
    return k;
  endfunction

  // floor(l * 255 / 100) = floor(floor(l * 51 / 4) / 5), the /5 by reciprocal
  function automatic logic [BYTE_W-1:0] grey_level(input logic [PCT_W-1:0] l);
    logic [12:0] l51;
    logic [10:0] x;
    logic [24:0] prod;
    l51  = 13'(l) * 13'd51;
    x    = l51[12:2];
    prod = 25'(x) * 25'd13108;
    return prod[23:16];
  endfunction

endpackage

`default_nettype wire

[rtl/hsl_to_rgb_converter_core.sv]
// Throughput: one item per clock; a stalled output freezes the whole pipeline.
// The pipeline runs front (1), fraction conversion (2), channel blend (3), output (1).
// Reset clears the valid bits only; payload registers are not reset.
`default_nettype none

module hsl_to_rgb_converter_core
  import hsl2rgb_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // hue_degrees[8:0], saturation_pct[15:9],
                                      // lightness_pct[22:16], zero pad
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata    // red[7:0], green[15:8], blue[23:16]
);

  localparam int STAGES   = 7;
  localparam int GREY_DLY = 5;
  localparam int RAMP_DLY = 2;

  logic [STAGES-1:0]    vld;
  logic                 en;
  logic [NUM_W-1:0]     qnum;
  logic [NUM_W-1:0]     pnum;
  ramp_t                ramp_s1;
  grey_t                grey_s1;
  ramp_t                ramp_dly [RAMP_DLY];
  grey_t                grey_dly [GREY_DLY];
  logic [FRAC_BITS+1:0] q;
  logic [FRAC_BITS+1:0] p;
  logic [BYTE_W-1:0]    red;
  logic [BYTE_W-1:0]    green;
  logic [BYTE_W-1:0]    blue;

  // Advance whenever the output register is free or being taken; refuse items in reset
  assign en       = !vld[STAGES-1] || m_tready;
  assign s_tready = en && !rst;
  assign m_tvalid = vld[STAGES-1];

  // Shift valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], s_tvalid};
    end
  end

  hsl2rgb_front u_front (
    .clk            (clk),
    .en             (en),
    .hue_degrees    (s_tdata[8:0]),
    .saturation_pct (s_tdata[15:9]),
    .lightness_pct  (s_tdata[22:16]),
    .qnum           (qnum),
    .pnum           (pnum),
    .ramp           (ramp_s1),
    .grey           (grey_s1)
  );

  hsl2rgb_frac #(.FRAC_BITS(FRAC_BITS)) u_frac_q (
    .clk  (clk),
    .en   (en),
    .num  (qnum),
    .frac (q)
  );

  hsl2rgb_frac #(.FRAC_BITS(FRAC_BITS)) u_frac_p (
    .clk  (clk),
    .en   (en),
    .num  (pnum),
    .frac (p)
  );

  // Carry ramp positions and the grey bypass alongside
  always_ff @(posedge clk) begin
    if (en) begin
      ramp_dly[0] <= ramp_s1;
      for (int i = 1; i < RAMP_DLY; i++) begin
        ramp_dly[i] <= ramp_dly[i-1];
      end
      grey_dly[0] <= grey_s1;
      for (int i = 1; i < GREY_DLY; i++) begin
        grey_dly[i] <= grey_dly[i-1];
      end
    end
  end

  hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_r (
    .clk   (clk),
    .en    (en),
    .q     (q),
    .p     (p),
    .ramp  (ramp_dly[RAMP_DLY-1].r),
    .level (red)
  );

  hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_g (
    .clk   (clk),
    .en    (en),
    .q     (q),
    .p     (p),
    .ramp  (ramp_dly[RAMP_DLY-1].g),
    .level (green)
  );

  hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_b (
    .clk   (clk),
    .en    (en),
    .q     (q),
    .p     (p),
    .ramp  (ramp_dly[RAMP_DLY-1].b),
    .level (blue)
  );

  // Output register: pick the truncated grey or the three channels
  always_ff @(posedge clk) begin
    if (en) begin
      if (grey_dly[GREY_DLY-1].grey) begin
        m_tdata <= {3{grey_dly[GREY_DLY-1].level}};
      end else begin
        m_tdata <= {blue, green, red};
      end
    end
  end

endmodule

`default_nettype wire

[rtl/hsl2rgb_front.sv]
// Input stage: clamp percents, reduce hue, form q and p numerators and ramp positions.
`default_nettype none

module hsl2rgb_front
  import hsl2rgb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [HUE_W-1:0] hue_degrees,
  input  wire logic [PCT_W-1:0] saturation_pct,
  input  wire logic [PCT_W-1:0] lightness_pct,
  output logic      [NUM_W-1:0] qnum,
  output logic      [NUM_W-1:0] pnum,
  output ramp_t                 ramp,
  output grey_t                 grey
);

  logic [PCT_W-1:0] s_c;
  logic [PCT_W-1:0] l_c;
  logic [HUE_W-1:0] h_mod;
  logic [HUE_W:0]   sum_r;
  logic [HUE_W:0]   sum_b;
  logic [HUE_W-1:0] d_r;
  logic [HUE_W-1:0] d_b;
  logic [NUM_W-1:0] ls;
  logic [NUM_W-1:0] qnum_next;
  logic [NUM_W-1:0] pnum_next;

  // Saturate percents and wrap hue
  always_comb begin
    s_c   = (saturation_pct > PCT_MAX) ? PCT_MAX : saturation_pct;
    l_c   = (lightness_pct > PCT_MAX) ? PCT_MAX : lightness_pct;
    h_mod = ({1'b0, hue_degrees} >= DEG_FULL) ?
            HUE_W'({1'b0, hue_degrees} - DEG_FULL) : hue_degrees;
  end

  // Phases of red and blue, wrapped into 0..359
  always_comb begin
    sum_r = {1'b0, h_mod} + DEG_RED;
    sum_b = {1'b0, h_mod} + DEG_BLUE;
    d_r   = (sum_r >= DEG_FULL) ? HUE_W'(sum_r - DEG_FULL) : sum_r[HUE_W-1:0];
    d_b   = (sum_b >= DEG_FULL) ? HUE_W'(sum_b - DEG_FULL) : sum_b[HUE_W-1:0];
  end

  // Numerators of q and p over 10000
  always_comb begin
    ls = NUM_W'(l_c) * NUM_W'(s_c);
    if (l_c >= PCT_HALF) begin
      qnum_next = NUM_W'(l_c) * NUM_W'(100) + NUM_W'(s_c) * NUM_W'(100) - ls;
    end else begin
      qnum_next = NUM_W'(l_c) * (NUM_W'(100) + NUM_W'(s_c));
    end
    pnum_next = NUM_W'(l_c) * NUM_W'(200) - qnum_next;
  end

  // Register the stage
  always_ff @(posedge clk) begin
    if (en) begin
      qnum       <= qnum_next;
      pnum       <= pnum_next;
      ramp.r     <= ramp_of(d_r);
      ramp.g     <= ramp_of(h_mod);
      ramp.b     <= ramp_of(d_b);
      grey.grey  <= (hue_degrees == '0) && (s_c == '0);
      grey.level <= grey_level(l_c);
    end
  end

endmodule

`default_nettype wire

[rtl/hsl2rgb_frac.sv]
// Two-stage conversion of a numerator over 10000 to an unsigned fixed-point fraction.
`default_nettype none

module hsl2rgb_frac
  import hsl2rgb_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [NUM_W-1:0]   num,
  output logic [FRAC_BITS+1:0]    frac
);

  localparam int FW = FRAC_BITS + 2;
  localparam int SH = NUM_W;
  localparam int PW = NUM_W + FW;
  localparam int RW = FRAC_BITS + NUM_W + 2;
  localparam longint unsigned RECIP = (64'd1 << (FRAC_BITS + SH)) / 64'd10000;
  localparam logic [FW-1:0] RECIP_C = FW'(RECIP);
  localparam logic [RW-1:0] DEN     = RW'(10000);
  localparam logic [RW-1:0] HALF    = RW'(5000);
  localparam logic [RW-1:0] TWO_DEN = RW'(20000);

  logic [PW-1:0]    prod;
  logic [NUM_W-1:0] num_s2;
  logic [FW-1:0]    est;
  logic [RW-1:0]    rem;

  // Estimate the quotient by reciprocal multiply, low by at most one
  always_ff @(posedge clk) begin
    if (en) begin
      prod   <= PW'(num) * PW'(RECIP_C);
      num_s2 <= num;
    end
  end

  // Correct the estimate from the remainder, rounding halves up
  always_comb begin
    est = prod[PW-1:SH];
    rem = (RW'(num_s2) << FRAC_BITS) + HALF - RW'(est) * DEN;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frac <= est + FW'(rem >= DEN) + FW'(rem >= TWO_DEN);
    end
  end

endmodule

`default_nettype wire

[rtl/hsl2rgb_chan.sv]
// One color channel: blend p and q along the ramp, scale to a rounded byte.
`default_nettype none

module hsl2rgb_chan
  import hsl2rgb_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [FRAC_BITS+1:0] q,
  input  wire logic [FRAC_BITS+1:0] p,
  input  wire logic [RAMP_W-1:0]    ramp,
  output logic      [BYTE_W-1:0]    level
);

  localparam int FW = FRAC_BITS + 2;
  localparam int TW = FRAC_BITS + 9;
  localparam int SW = FRAC_BITS + 17;
  localparam int WW = 12;
  localparam logic [SW-1:0] ROUND_C = SW'(30) << FRAC_BITS;

  logic [FW-1:0]     pc;
  logic [FW-1:0]     base_p;
  logic [FW-1:0]     diff;
  logic [RAMP_W-1:0] ramp_a;
  logic [TW-1:0]     t;
  logic [SW-1:0]     scaled;
  logic [WW-1:0]     w;
  logic [24:0]       recip_prod;

  // Clamp p to q and take the swing
  always_comb begin
    pc = (p > q) ? q : p;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base_p <= pc;
      diff   <= q - pc;
      ramp_a <= ramp;
    end
  end

  // Blend: p*60 + (q - p)*k
  always_ff @(posedge clk) begin
    if (en) begin
      t <= TW'(base_p) * TW'(60) + TW'(diff) * TW'(ramp_a);
    end
  end

  // Scale by 255, add half of 60*2^F, drop the power-of-two part of the divisor
  always_comb begin
    scaled = SW'(t) * SW'(255) + ROUND_C;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w <= scaled[FRAC_BITS+WW+1:FRAC_BITS+2];
    end
  end

  // Divide by 15 through reciprocal and clamp
  always_comb begin
    recip_prod = 25'(w) * 25'd4370;
    level      = recip_prod[24] ? '1 : recip_prod[23:16];
  end

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the HSL to RGB converter core.
`default_nettype none

module tb_top
  import hsl2rgb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS  = 16;
  localparam int LATENCY    = 7;
  localparam int LONG_STALL = 150;
  localparam int CYCLE_CAP  = 200000;

  // Result item with red in the lowest byte, as on m_tdata
  typedef struct packed {
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] red;
  } rgb_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  rgb_t rgb_expected[$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   long_stall_req = 1'b0;

  hsl_to_rgb_converter_core #(
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Round a numerator over 10000 to a Q1.FRAC_BITS fraction, halves up
  function automatic longint unsigned pct2_to_frac(input longint unsigned num);
    return ((num << FRAC_BITS) + 64'd5000) / 64'd10000;
  endfunction

  // Blend one channel from its phase in whole degrees
  function automatic logic [BYTE_W-1:0] channel_byte(input longint unsigned deg,
                                                     input longint unsigned q,
                                                     input longint unsigned p);
    longint unsigned k;
    longint unsigned num;
    longint unsigned den;
    longint unsigned v;
    den = 64'd60 << FRAC_BITS;
    if (deg < 60) begin
      k = deg;
    end else if (deg < 180) begin
      k = 60;
    end else if (deg < 240) begin
      k = 240 - deg;
    end else begin
      k = 0;
    end
    num = (p * 60 + (q - p) * k) * 255;
    v = (num + den / 2) / den;
    return (v > 255) ? 8'd255 : v[BYTE_W-1:0];
  endfunction

  // Expected color for one HSL item
  function automatic rgb_t hsl_to_rgb_expected(input logic [HUE_W-1:0] hue,
                                               input logic [PCT_W-1:0] sat_in,
                                               input logic [PCT_W-1:0] lit_in);
    longint unsigned sat;
    longint unsigned lit;
    longint unsigned qnum;
    longint unsigned q;
    longint unsigned p;
    longint unsigned h;
    longint unsigned grey;
    rgb_t rgb;
    sat = (sat_in > PCT_MAX) ? 100 : sat_in;
    lit = (lit_in > PCT_MAX) ? 100 : lit_in;
    // Grey bypass looks at the raw hue, truncates the level
    if (hue == 0 && sat == 0) begin
      grey = (lit * 255) / 100;
      rgb.red   = grey[BYTE_W-1:0];
      rgb.green = grey[BYTE_W-1:0];
      rgb.blue  = grey[BYTE_W-1:0];
      return rgb;
    end
    if (lit >= 50) begin
      qnum = lit * 100 + sat * 100 - lit * sat;
    end else begin
      qnum = lit * (100 + sat);
    end
    q = pct2_to_frac(qnum);
    p = pct2_to_frac(lit * 200 - qnum);
    if (p > q) begin
      p = q;
    end
    h = hue % DEG_FULL;
    rgb.red   = channel_byte((h + 120) % 360, q, p);
    rgb.green = channel_byte(h, q, p);
    rgb.blue  = channel_byte((h + 240) % 360, q, p);
    return rgb;
  endfunction

  // Predict on input accept, check on output accept; sampled mid-cycle
  always @(negedge clk) begin
    rgb_t got;
    rgb_t want;
    if (!rst && s_tvalid && s_tready) begin
      rgb_expected.push_back(hsl_to_rgb_expected(s_tdata[8:0], s_tdata[15:9],
                                                 s_tdata[22:16]));
    end
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (rgb_expected.size() == 0) begin
        $error("unexpected result item: red %0d green %0d blue %0d",
               got.red, got.green, got.blue);
        mismatch_count++;
      end else begin
        want = rgb_expected.pop_front();
        if (got.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, got.red);
          mismatch_count++;
        end
        if (got.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, got.green);
          mismatch_count++;
        end
        if (got.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, got.blue);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver: random ready, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one item, with random gaps ahead of it, and hold until accepted
  task automatic send_hsl(input int unsigned hue, input int unsigned sat,
                          input int unsigned lit);
    bit ready_seen;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, PCT_W'(lit), PCT_W'(sat), HUE_W'(hue)};
    forever begin
      @(negedge clk);
      ready_seen = s_tready;
      @(posedge clk);
      if (ready_seen) break;
    end
  endtask

  // Mostly well-formed colors, some grey, some out-of-range noise
  task automatic send_random_hsl();
    case ($urandom_range(19))
      0: send_hsl($urandom_range(511), $urandom_range(127), $urandom_range(127));
      1: send_hsl(0, 0, $urandom_range(100));
      default: send_hsl($urandom_range(359), $urandom_range(100), $urandom_range(100));
    endcase
  endtask

  task automatic wait_drained();
    while (rgb_expected.size() != 0) @(posedge clk);
  endtask

  // Field extremes, breakpoints, grey and saturation corner cases
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_hsl(0, 0, 0);
    send_hsl(0, 0, 100);
    send_hsl(0, 0, 37);
    send_hsl(0, 0, 127);
    send_hsl(1, 0, 37);
    send_hsl(360, 0, 37);
    send_hsl(0, 100, 50);
    send_hsl(120, 100, 50);
    send_hsl(240, 100, 50);
    send_hsl(359, 100, 50);
    send_hsl(59, 80, 49);
    send_hsl(60, 80, 49);
    send_hsl(179, 80, 51);
    send_hsl(180, 80, 51);
    send_hsl(239, 55, 75);
    send_hsl(511, 127, 127);
    send_hsl(400, 101, 101);
    send_hsl(300, 127, 0);
    send_hsl(200, 64, 100);
    send_hsl(256, 1, 1);
    send_hsl(0, 1, 99);
  endtask

  task automatic test_random_phase(input int send_idle, input int recv_idle, input int n);
    send_idle_pct = send_idle;
    recv_idle_pct = recv_idle;
    repeat (n) send_random_hsl();
  endtask

  // Hold the receiver off long enough to fill the pipeline and stall input
  task automatic test_long_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_stall_req = 1'b1;
    repeat (40) send_random_hsl();
  endtask

  // Pause the sender until every result is back, then resume
  task automatic test_drain_pause();
    send_idle_pct = 0;
    recv_idle_pct = 30;
    repeat (12) send_random_hsl();
    s_tvalid <= 1'b0;
    wait_drained();
    @(posedge clk);
    repeat (12) send_random_hsl();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phase(15, 86, 380);
    test_random_phase(86, 15, 380);
    test_long_stall();
    test_drain_pause();
    test_random_phase(0, 0, 380);
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (LATENCY + 5) @(posedge clk);
    if (mismatch_count == 0 && rgb_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/hsl2rgb_pkg.sv
rtl/hsl2rgb_front.sv
rtl/hsl2rgb_frac.sv
rtl/hsl2rgb_chan.sv
rtl/hsl_to_rgb_converter_core.sv
test/tb_top.sv
